@@ rtl/a429fp_pkg.sv @@
// ----------------------------------------------------------------------------
// a429fp_pkg
// Shared types and constants for the ARINC 429 field packer: the word
// payloads, request type codes, controller states and controller commands.
// ----------------------------------------------------------------------------
package a429fp_pkg;

  // Word and field geometry.
  localparam int unsigned WordBits    = 32;
  localparam int unsigned DivBits     = 16;
  localparam int unsigned BcdDigits   = 8;
  localparam int unsigned DigitBits   = 4;
  localparam int unsigned BnrSignBit  = 28;
  localparam int unsigned SsmLowBit   = 29;
  localparam int unsigned SsmHighBit  = 30;

  // Request type codes carried in req_type.
  localparam logic [2:0] REQ_BITFIELD  = 3'd0;
  localparam logic [2:0] REQ_BOOLEAN   = 3'd1;
  localparam logic [2:0] REQ_BNR_S     = 3'd2;
  localparam logic [2:0] REQ_BNR_U     = 3'd3;
  localparam logic [2:0] REQ_BCD       = 3'd4;
  localparam logic [2:0] REQ_VALIDITY  = 3'd5;

  // Input word.
  typedef struct packed {
    logic        [2:0]  req_type;
    logic        [31:0] old_word;
    logic signed [31:0] param_value;
    logic        [5:0]  field_size;
    logic        [4:0]  field_offset;
    logic        [15:0] lsb_divisor;
  } fp_in_t;

  // Result word.
  typedef struct packed {
    logic [31:0] new_word;
    logic        divide_error;
  } fp_out_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WRITE
  } fp_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic emit;
  } fp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic needs_div;
    logic last_step;
  } fp_status_t;

endpackage

@@ rtl/a429fp_ctrl.sv @@
// ----------------------------------------------------------------------------
// a429fp_ctrl
// Controller for the field packer: accepts a word, sequences the divider
// steps and hands the finished word to the output register.
// ----------------------------------------------------------------------------
module a429fp_ctrl import a429fp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  fp_status_t status_i,
  output fp_cmd_t    cmd_o
);

  fp_state_e state_q, state_d;
  logic      out_valid_q, out_valid_d;
  logic      out_free;

  // State and output valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // The output register can take a new word when it is empty or being read.
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd_o.step = 1'b1;
        if (!status_i.needs_div || status_i.last_step) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // A new word stays valid until it is taken.
  assign out_valid_d = cmd_o.emit | (out_valid_q & out_stall_i);

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/a429fp_datapath.sv @@
// ----------------------------------------------------------------------------
// a429fp_datapath
// Datapath for the field packer: the captured word, a radix-2 restoring
// divider that feeds a double-dabble BCD converter, and the field insertion.
// ----------------------------------------------------------------------------
module a429fp_datapath import a429fp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  fp_in_t      in_data_i,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i,
  input  fp_cmd_t     cmd_i,
  output fp_status_t  status_o,
  output fp_out_t     out_data_o
);

  logic [31:0] normal_op_code_q;
  fp_in_t      item_q;
  logic [15:0] rem_q, rem_d;
  logic [31:0] num_q, num_d;
  logic [31:0] quo_q, quo_d;
  logic [31:0] bcd_q, bcd_d;
  logic [4:0]  cnt_q;
  fp_out_t     out_q, out_d;

  logic        in_neg;
  logic [31:0] in_mag;
  logic [16:0] rem_sh;
  logic [16:0] trial;
  logic        qbit;
  logic [31:0] bcd_adj;
  logic        div_mode;
  logic        div_zero;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normal_op_code_q <= '0;
    end else if (cfg_we_i) begin
      normal_op_code_q <= cfg_data_i;
    end
  end

  // Magnitude of the incoming value; the most negative value maps to 2^31.
  assign in_neg = in_data_i.param_value[31];
  assign in_mag = in_neg ? (~in_data_i.param_value + 32'd1) : in_data_i.param_value;

  // One restoring divide step: shift in the next dividend bit and subtract.
  assign rem_sh = {rem_q, num_q[31]};
  assign trial  = rem_sh - {1'b0, item_q.lsb_divisor};
  assign qbit   = (rem_sh >= {1'b0, item_q.lsb_divisor});
  assign rem_d  = qbit ? trial[15:0] : rem_sh[15:0];
  assign num_d  = {num_q[30:0], 1'b0};
  assign quo_d  = {quo_q[30:0], qbit};

  // Double dabble on the quotient bits as they appear, most significant
  // first. Only the low eight decimal digits are kept.
  always_comb begin
    for (int i = 0; i < BcdDigits; i++) begin
      if (bcd_q[i*DigitBits +: DigitBits] >= 4'd5) begin
        bcd_adj[i*DigitBits +: DigitBits] = bcd_q[i*DigitBits +: DigitBits] + 4'd3;
      end else begin
        bcd_adj[i*DigitBits +: DigitBits] = bcd_q[i*DigitBits +: DigitBits];
      end
    end
  end
  assign bcd_d = {bcd_adj[30:0], qbit};

  // Captured word and divider registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
      num_q  <= in_mag;
      rem_q  <= '0;
      quo_q  <= '0;
      bcd_q  <= '0;
    end else if (cmd_i.step) begin
      num_q  <= num_d;
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      bcd_q  <= bcd_d;
    end
  end

  // Step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load) begin
      cnt_q <= '0;
    end else if (cmd_i.step) begin
      cnt_q <= cnt_q + 5'd1;
    end
  end

  // Status towards the controller.
  assign div_mode = (item_q.req_type == REQ_BNR_S) || (item_q.req_type == REQ_BNR_U) ||
                    (item_q.req_type == REQ_BCD);
  assign div_zero = (item_q.lsb_divisor == '0);
  assign status_o.needs_div = div_mode && !div_zero;
  assign status_o.last_step = (cnt_q == 5'd31);

  // Field insertion for the finished word.
  always_comb begin
    logic [5:0]  size_c;
    logic [31:0] ones_c;
    logic [31:0] mask_sh;
    logic [31:0] mask_plain;
    logic [31:0] raw;
    logic [31:0] word;
    logic [31:0] quo_s;
    logic [31:0] valid_bit;
    logic [31:0] bool_mask;
    logic        neg;

    size_c     = (item_q.field_size > 6'd32) ? 6'd32 : item_q.field_size;
    ones_c     = size_c[5] ? '1 : ((32'd1 << size_c[4:0]) - 32'd1);
    mask_sh    = ones_c << item_q.field_offset;
    mask_plain = size_c[5] ? '1 : mask_sh;
    raw        = item_q.param_value;
    word       = item_q.old_word;
    neg        = raw[31];
    quo_s      = neg ? (~quo_q + 32'd1) : quo_q;
    valid_bit  = {31'd0, (raw == normal_op_code_q)};
    bool_mask  = 32'd1 << item_q.field_offset;

    out_d.divide_error = div_mode && div_zero;
    out_d.new_word     = word;

    unique case (item_q.req_type)
      REQ_BITFIELD: begin
        out_d.new_word = (word & ~mask_plain) | ((raw << item_q.field_offset) & mask_plain);
      end
      REQ_BOOLEAN: begin
        out_d.new_word = (word & ~bool_mask) | ({31'd0, raw[0]} << item_q.field_offset);
      end
      REQ_BNR_S, REQ_BNR_U: begin
        if (!div_zero) begin
          out_d.new_word = (word & ~mask_sh) | ((quo_s << item_q.field_offset) & mask_sh);
          if (item_q.req_type == REQ_BNR_S) begin
            out_d.new_word[BnrSignBit] = neg;
          end
        end
      end
      REQ_BCD: begin
        if (!div_zero) begin
          out_d.new_word = (word & ~mask_sh) | ((bcd_q << item_q.field_offset) & mask_sh);
          out_d.new_word[SsmLowBit]  = neg;
          out_d.new_word[SsmHighBit] = neg;
        end
      end
      REQ_VALIDITY: begin
        out_d.new_word = (word & ~mask_plain) |
                         ((valid_bit << item_q.field_offset) & mask_plain);
      end
      default: begin
        out_d.new_word = word;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

@@ rtl/a429_field_packer.sv @@
// In BNR and BCD modes with a non-zero divisor each word runs through the
// 32 single-bit steps of the shared restoring divider; in all other cases
// the divide is skipped. No new word is taken until the finished word is
// handed to the output register, which waits while a stalled result is held.
// Reset clears the controller, the output valid and normal_op_code to zero.
// ----------------------------------------------------------------------------
// a429_field_packer
// Inserts one parameter field (bitfield, boolean, BNR, BCD or validity) into
// a 32-bit ARINC 429 message word.
// ----------------------------------------------------------------------------
module a429_field_packer import a429fp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  fp_in_t      in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output fp_out_t     out_data_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i
);

  fp_cmd_t    cmd;
  fp_status_t status;

  // Sequencing.
  a429fp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Divider, BCD conversion and field insertion.
  a429fp_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

@@ rtl/a429fp_checker.sv @@
// ----------------------------------------------------------------------------
// a429fp_checker
// Port-level checks for the field packer, bound to the top level.
// ----------------------------------------------------------------------------
module a429fp_checker import a429fp_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input fp_out_t     out_data_o
);

  // A stalled result word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result word changed or was dropped");

  // Once a word is taken the block is busy with it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block not busy after accepting a word");

  // No new result appears in the cycle right after a word is accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result appeared too early");

  // Reset leaves no result pending.
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

endmodule

bind a429_field_packer a429fp_checker u_checker (.*);
